### hdl/wwr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwr_pkg
// Shared types, register indexes and byte constants for the whole-word
// find-and-replace stream block.
// ----------------------------------------------------------------------------
package wwr_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MATCH_WORD   = 3'd0;
  localparam logic [2:0] CFG_MATCH_LENGTH = 3'd1;
  localparam logic [2:0] CFG_NEW_WORD     = 3'd2;
  localparam logic [2:0] CFG_NEW_LENGTH   = 3'd3;
  localparam logic [2:0] CFG_IGNORE_CASE  = 3'd4;

  localparam logic [7:0] SPACE_BYTE  = 8'd32;
  localparam logic [7:0] UPPER_A     = 8'd65;
  localparam logic [7:0] UPPER_Z     = 8'd90;
  localparam logic [7:0] CASE_OFFSET = 8'd32;
  localparam logic [3:0] WORD_BYTES  = 4'd8;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       out_last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic plan;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_ready;
    logic pend;
    logic one_left;
  } dp_stat_t;

  // Folds ASCII A-Z to a-z and leaves every other byte alone.
  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UPPER_A && b <= UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

### hdl/wwr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwr_ctrl
// Controller: takes one transaction, has the datapath plan its results and
// then steps the results out one per cycle as the output register frees up.
// ----------------------------------------------------------------------------
module wwr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output wwr_pkg::dp_cmd_t  cmd,
  input  wwr_pkg::dp_stat_t stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLAN,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;
  logic   in_stall_nxt;

  always_comb begin
    cmd          = '0;
    state_nxt    = state_r;
    in_stall_nxt = in_stall_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          state_nxt    = ST_PLAN;
          in_stall_nxt = 1'b1;
        end
      end
      ST_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit = stat.pend && stat.out_ready;
        if (!stat.pend || (cmd.emit && stat.one_left)) begin
          state_nxt    = ST_IDLE;
          in_stall_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt    = ST_IDLE;
        in_stall_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

endmodule

### hdl/wwr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwr_dp
// Datapath: configuration registers, word buffer with a running pattern
// compare, result planning and the output register.
// ----------------------------------------------------------------------------
module wwr_dp #(
  parameter int MAX_WORD = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  wwr_pkg::in_item_t  in_data,
  input  logic               out_stall,
  output logic               out_valid,
  output wwr_pkg::out_item_t out_data,
  input  wwr_pkg::dp_cmd_t   cmd,
  output wwr_pkg::dp_stat_t  stat
);

  localparam int FILL_W = $clog2(MAX_WORD + 1);
  localparam int IDX_W  = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  // Configuration.
  logic [63:0] match_word_r;
  logic [3:0]  match_len_r;
  logic [63:0] new_word_r;
  logic [3:0]  new_len_r;
  logic        ignore_case_r;

  // Word state.
  logic [7:0]        store_r [MAX_WORD];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              ovf_r, ovf_nxt;
  logic              run_eq_r, run_eq_nxt;
  logic              store_we;

  // Latched transaction and result plan.
  logic [7:0] byte_r;
  logic       last_r;
  logic       sel_new_r, sel_new_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       extra_r, extra_nxt;
  logic       mark_r, mark_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  wwr_pkg::out_item_t  out_r, out_nxt;

  logic       is_space;
  logic       fill_full;
  logic [2:0] pidx;
  logic [7:0] pat_byte;
  logic       byte_eq;
  logic       word_hit;
  logic       grow_hit;
  logic [3:0] new_len_c;
  logic [2:0] nidx;
  logic [7:0] word_byte;
  logic       pend_word;
  logic       out_ready;
  logic       one_left;

  assign is_space  = (byte_r == wwr_pkg::SPACE_BYTE);
  assign fill_full = (fill_r == FILL_W'(MAX_WORD));
  assign pidx      = 3'(fill_r);
  assign pat_byte  = match_word_r[{pidx, 3'b000} +: 8];
  assign byte_eq   = ignore_case_r ?
                     (wwr_pkg::fold_byte(byte_r) == wwr_pkg::fold_byte(pat_byte)) :
                     (byte_r == pat_byte);
  // Match of the word as it stands, and of the word with the new byte added.
  assign word_hit  = run_eq_r && (match_len_r == 4'(fill_r));
  assign grow_hit  = run_eq_r && byte_eq && (match_len_r == 4'(fill_r) + 4'd1);
  assign new_len_c = (new_len_r > wwr_pkg::WORD_BYTES) ? wwr_pkg::WORD_BYTES : new_len_r;

  assign nidx      = 3'(idx_r);
  assign word_byte = sel_new_r ? new_word_r[{nidx, 3'b000} +: 8] : store_r[idx_r[IDX_W-1:0]];
  assign pend_word = (idx_r != cnt_r);
  assign out_ready = !out_valid_r || !out_stall;
  assign one_left  = pend_word ? ((idx_r + 4'd1 == cnt_r) && !extra_r && !mark_r)
                               : (extra_r || mark_r);

  assign stat.out_ready = out_ready;
  assign stat.pend      = pend_word || extra_r || mark_r;
  assign stat.one_left  = one_left;

  // Planning step: update the word state and decide what goes out. Each
  // emitted result then advances the plan by one.
  always_comb begin
    fill_nxt    = fill_r;
    ovf_nxt     = ovf_r;
    run_eq_nxt  = run_eq_r;
    store_we    = 1'b0;
    sel_new_nxt = sel_new_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    extra_nxt   = extra_r;
    mark_nxt    = mark_r;
    if (cmd.plan) begin
      idx_nxt     = 4'd0;
      sel_new_nxt = 1'b0;
      cnt_nxt     = 4'd0;
      extra_nxt   = 1'b0;
      if (is_space) begin
        if (!ovf_r) begin
          sel_new_nxt = word_hit;
          cnt_nxt     = word_hit ? new_len_c : 4'(fill_r);
        end
        extra_nxt  = !last_r;
        fill_nxt   = '0;
        ovf_nxt    = 1'b0;
        run_eq_nxt = 1'b1;
      end else if (ovf_r) begin
        extra_nxt = 1'b1;
      end else if (!fill_full) begin
        store_we   = 1'b1;
        fill_nxt   = fill_r + FILL_W'(1);
        run_eq_nxt = run_eq_r && byte_eq;
        if (last_r) begin
          sel_new_nxt = grow_hit;
          cnt_nxt     = grow_hit ? new_len_c : 4'(fill_r) + 4'd1;
        end
      end else begin
        // Word outgrew the buffer: flush it and pass the rest through.
        cnt_nxt    = 4'(fill_r);
        extra_nxt  = 1'b1;
        fill_nxt   = '0;
        ovf_nxt    = 1'b1;
        run_eq_nxt = 1'b1;
      end
      if (last_r) begin
        fill_nxt   = '0;
        ovf_nxt    = 1'b0;
        run_eq_nxt = 1'b1;
      end
      mark_nxt = last_r && (cnt_nxt == 4'd0) && !extra_nxt;
    end
    if (cmd.emit) begin
      if (pend_word) begin
        idx_nxt = idx_r + 4'd1;
      end else if (extra_r) begin
        extra_nxt = 1'b0;
      end else begin
        mark_nxt = 1'b0;
      end
    end
  end

  // Output step: word bytes, then the passed byte, or else an end marker.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt      = 1'b1;
      out_nxt.byte_valid = 1'b1;
      out_nxt.out_last   = last_r && one_left;
      if (pend_word) begin
        out_nxt.out_byte = word_byte;
      end else if (extra_r) begin
        out_nxt.out_byte = byte_r;
      end else begin
        out_nxt.out_byte   = 8'd0;
        out_nxt.byte_valid = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_word_r  <= '0;
      match_len_r   <= '0;
      new_word_r    <= '0;
      new_len_r     <= '0;
      ignore_case_r <= 1'b0;
      fill_r        <= '0;
      ovf_r         <= 1'b0;
      run_eq_r      <= 1'b1;
      cnt_r         <= '0;
      idx_r         <= '0;
      extra_r       <= 1'b0;
      mark_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wwr_pkg::CFG_MATCH_WORD:   match_word_r  <= cfg_data;
          wwr_pkg::CFG_MATCH_LENGTH: match_len_r   <= cfg_data[3:0];
          wwr_pkg::CFG_NEW_WORD:     new_word_r    <= cfg_data;
          wwr_pkg::CFG_NEW_LENGTH:   new_len_r     <= cfg_data[3:0];
          wwr_pkg::CFG_IGNORE_CASE:  ignore_case_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      fill_r      <= fill_nxt;
      ovf_r       <= ovf_nxt;
      run_eq_r    <= run_eq_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      extra_r     <= extra_nxt;
      mark_r      <= mark_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_data.text_byte;
      last_r <= in_data.text_last;
    end
    if (store_we) begin
      store_r[fill_r[IDX_W-1:0]] <= byte_r;
    end
    sel_new_r <= sel_new_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hdl/whole_word_replace_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whole_word_replace_stream
// Whole-word find and replace on a byte stream.
// ----------------------------------------------------------------------------
// The block takes text one byte per transaction and splits it into words at
// every single space, so two spaces in a row enclose an empty word. Each word
// is held in a buffer of MAX_WORD bytes and compared with the pattern word as
// it fills, either exactly or with A-Z folded to a-z. A word equal to the
// pattern goes out as the replacement word; any other word goes out as it
// came. Spaces pass through, except a space that is the last byte of a text.
// A word longer than the buffer is flushed unchanged and never matches. The
// final result of each text carries out_last; a last byte that produces no
// output yields one bare end marker with byte_valid low. Each input
// transaction is first accepted, then its results (up to nine) are planned,
// and they then step out one per cycle through the single output register
// while out_stall does not hold it. The output register lets the next input
// be accepted while the last result still waits to be taken. Configuration
// registers may be written only while no transaction is in flight.
// ----------------------------------------------------------------------------
module whole_word_replace_stream #(
  parameter int MAX_WORD = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  wwr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output wwr_pkg::out_item_t out_data
);

  // Command and status between the controller and the datapath.
  wwr_pkg::dp_cmd_t  cmd;
  wwr_pkg::dp_stat_t stat;

  // The controller sequences accept, plan and emit.
  wwr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // The datapath holds the word, the configuration and the output register.
  wwr_dp #(
    .MAX_WORD (MAX_WORD)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

`ifndef SYNTH
  // Every accepted transaction is planned in the following cycle.
  a_load_then_plan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.plan)
    else $error("load not followed by plan");

  // A result is never written over one that has not been taken.
  a_emit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_ready)
    else $error("emit while output register is blocked");

  // A new transaction is only accepted once all earlier results have been emitted.
  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !stat.pend)
    else $error("accept with results still pending");
`endif

endmodule
